// ===== hdl/sskq_pkg.sv =====
// Shared types and codes for the stable sorted key queue.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package sskq_pkg;

   localparam int KEY_BITS     = 32;
   localparam int ID_PORT_BITS = 8;
   localparam int OCC_BITS     = 5;

   // Operation codes carried in the request mode field.
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_LOOKUP = 2'd3;

   // Status codes carried in the response.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]                     mode;
      logic [ID_PORT_BITS-1:0]        entry_id;
      logic signed [KEY_BITS-1:0]     entry_key;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic [ID_PORT_BITS-1:0]        out_id;
      logic signed [KEY_BITS-1:0]     out_key;
      logic                           found;
      logic [OCC_BITS-1:0]            occupancy;
   } rsp_payload_type;

endpackage

// ===== hdl/sskq_req_if.sv =====
// Request channel of the stable sorted key queue: valid, ready and payload.
// Depends on sskq_pkg for the payload type.
`timescale 1ns / 1ps

interface sskq_req_if;
   logic                     valid;
   logic                     ready;
   sskq_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/sskq_rsp_if.sv =====
// Response channel of the stable sorted key queue: valid, ready and payload.
// Depends on sskq_pkg for the payload type.
`timescale 1ns / 1ps

interface sskq_rsp_if;
   logic                     valid;
   logic                     ready;
   sskq_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/sskq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sskq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/stable_sorted_key_queue_top.sv =====
// Top level of the stable sorted key queue: control sequencer around one RAM.
// Depends on sskq_pkg, sskq_req_if, sskq_rsp_if and sskq_ram.
`timescale 1ns / 1ps

// The queue holds up to QUEUE_DEPTH entries (id, signed key) in one RAM, sorted by
// ascending key with ties kept in arrival order, slot 0 being the head. One
// transaction is worked at a time, and the sequencer walks the RAM one slot per
// cycle through its single read port. A pop or remove walks every queued entry, a
// look-up stops at the slot of the match, and an insert walks back from the tail
// over the entries with a greater key. Full inserts and operations on an empty
// queue read no slot. A finished response sits in an output register, so the next
// request is accepted while it waits. The RAM needs no clearing after reset: only
// slots below the entry count are read.
module stable_sorted_key_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   sskq_req_if.sink   req_chan,
   sskq_rsp_if.source rsp_chan
);

   localparam int IdxW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int KeyW = sskq_pkg::KEY_BITS;
   localparam int RamW = ID_BITS + KeyW;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FWD  = 3'd1;
   localparam logic [2:0] S_BWD  = 3'd2;
   localparam logic [2:0] S_BFIN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [1:0]         mode_ff, mode_in;
   logic [ID_BITS-1:0] opid_ff, opid_in;
   logic [KeyW-1:0]    opkey_ff, opkey_in;
   logic [IdxW-1:0]    raddr_ff, raddr_in;
   logic               hit_ff, hit_in;
   logic [1:0]         rstat_ff, rstat_in;
   logic [ID_BITS-1:0] rid_ff, rid_in;
   logic [KeyW-1:0]    rkey_ff, rkey_in;
   logic               rfound_ff, rfound_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sskq_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [IdxW-1:0]    ram_waddr;
   logic [RamW-1:0]    ram_wdata;
   logic               ram_re;
   logic [IdxW-1:0]    ram_raddr;
   logic [RamW-1:0]    ram_rdata;

   logic               req_accept;
   logic [ID_BITS-1:0] req_id;
   logic [ID_BITS-1:0] rd_id;
   logic [KeyW-1:0]    rd_key;
   logic [RamW-1:0]    new_entry;
   logic               rd_greater;
   logic               fwd_last;
   logic               fwd_match;
   logic               count_zero;
   logic               count_full;

   sskq_ram #(
      .WIDTH (RamW),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == S_IDLE);
   assign req_id         = ID_BITS'(req_chan.payload.entry_id);

   assign rd_id      = ram_rdata[RamW-1:KeyW];
   assign rd_key     = ram_rdata[KeyW-1:0];
   assign new_entry  = {opid_ff, opkey_ff};
   assign rd_greater = $signed(rd_key) > $signed(opkey_ff);
   assign fwd_last   = (CntW'(raddr_ff) + CntW'(1)) == count_ff;
   assign fwd_match  = (mode_ff == sskq_pkg::MODE_POP) || (rd_id == opid_ff);
   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == CntW'(QUEUE_DEPTH));

   // Inserts walk from the tail toward the head, moving each greater entry up by
   // one; removals walk from the head and, past the match, move each entry down.
   // The write always trails the read by two slots, so no read sees a stale slot.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      opid_in      = opid_ff;
      opkey_in     = opkey_ff;
      raddr_in     = raddr_ff;
      hit_in       = hit_ff;
      rstat_in     = rstat_ff;
      rid_in       = rid_ff;
      rkey_in      = rkey_ff;
      rfound_in    = rfound_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = new_entry;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in  = req_chan.payload.mode;
               opid_in  = req_id;
               opkey_in = req_chan.payload.entry_key;
               hit_in   = 1'b0;
               if (req_chan.payload.mode == sskq_pkg::MODE_INSERT) begin
                  rstat_in  = sskq_pkg::STAT_OK;
                  rid_in    = req_id;
                  rkey_in   = req_chan.payload.entry_key;
                  rfound_in = 1'b0;
                  if (count_full) begin
                     rstat_in = sskq_pkg::STAT_FULL;
                     state_in = S_DONE;
                  end else if (count_zero) begin
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     ram_wdata = {req_id, req_chan.payload.entry_key};
                     count_in  = count_ff + CntW'(1);
                     state_in  = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = IdxW'(count_ff - CntW'(1));
                     raddr_in  = IdxW'(count_ff - CntW'(1));
                     state_in  = S_BWD;
                  end
               end else begin
                  rfound_in = 1'b0;
                  rkey_in   = '0;
                  if (req_chan.payload.mode == sskq_pkg::MODE_POP) begin
                     rstat_in = sskq_pkg::STAT_EMPTY;
                     rid_in   = '0;
                  end else begin
                     rstat_in = sskq_pkg::STAT_NOTFOUND;
                     rid_in   = req_id;
                  end
                  if (count_zero) begin
                     state_in = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     raddr_in  = '0;
                     state_in  = S_FWD;
                  end
               end
            end
         end

         S_BWD: begin
            ram_we    = 1'b1;
            ram_waddr = raddr_ff + 1'b1;
            if (rd_greater) begin
               ram_wdata = ram_rdata;
               if (raddr_ff == '0) begin
                  state_in = S_BFIN;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = raddr_ff - 1'b1;
                  raddr_in  = raddr_ff - 1'b1;
               end
            end else begin
               ram_wdata = new_entry;
               count_in  = count_ff + CntW'(1);
               state_in  = S_DONE;
            end
         end

         S_BFIN: begin
            // Every queued key was greater, so the new entry becomes the head.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = new_entry;
            count_in  = count_ff + CntW'(1);
            state_in  = S_DONE;
         end

         S_FWD: begin
            if (hit_ff) begin
               ram_we    = 1'b1;
               ram_waddr = raddr_ff - 1'b1;
               ram_wdata = ram_rdata;
            end else if (fwd_match) begin
               rstat_in  = sskq_pkg::STAT_OK;
               rid_in    = rd_id;
               rkey_in   = rd_key;
               rfound_in = (mode_ff != sskq_pkg::MODE_POP);
               hit_in    = 1'b1;
            end
            if (!hit_ff && fwd_match && (mode_ff == sskq_pkg::MODE_LOOKUP)) begin
               state_in = S_DONE;
            end else if (fwd_last) begin
               if (hit_ff || fwd_match) begin
                  count_in = count_ff - CntW'(1);
               end
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = raddr_ff + 1'b1;
               raddr_in  = raddr_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = rstat_ff;
               rsp_data_in.out_id    = sskq_pkg::ID_PORT_BITS'(rid_ff);
               rsp_data_in.out_key   = rkey_ff;
               rsp_data_in.found     = rfound_ff;
               rsp_data_in.occupancy = sskq_pkg::OCC_BITS'(count_ff);
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      opid_ff     <= opid_in;
      opkey_ff    <= opkey_in;
      raddr_ff    <= raddr_in;
      rstat_ff    <= rstat_in;
      rid_ff      <= rid_in;
      rkey_ff     <= rkey_in;
      rfound_ff   <= rfound_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ===== dv/sskq_checker.sv =====
// Response checker for the stable sorted key queue: keeps its own sorted queue,
// predicts each response from the accepted requests and compares it field by field.
// Depends on sskq_pkg, sskq_req_if and sskq_rsp_if.
`timescale 1ns / 1ps

module sskq_checker
   import sskq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   sskq_req_if  req_chan,
   sskq_rsp_if  rsp_chan,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   full_hits,
   output int   empty_hits,
   output int   absent_hits
);

   logic signed [KEY_BITS-1:0]     slot_key [QUEUE_DEPTH];
   logic        [ID_PORT_BITS-1:0] slot_id  [QUEUE_DEPTH];
   int                             occ;

   rsp_payload_type outcome_fifo[$];
   rsp_payload_type want;
   rsp_payload_type got;

   // Close the gap left by the entry at slot pos.
   function automatic void close_slot(input int pos);
      for (int i = pos; i + 1 < occ; i++) begin
         slot_key[i] = slot_key[i + 1];
         slot_id[i]  = slot_id[i + 1];
      end
      occ--;
   endfunction

   // Apply one request to the shadow queue and return the response it should give.
   function automatic rsp_payload_type queue_op(input req_payload_type rq);
      rsp_payload_type rs;
      int              slot;
      rs   = '0;
      slot = 0;
      case (rq.mode)
         MODE_INSERT: begin
            rs.out_id  = rq.entry_id;
            rs.out_key = rq.entry_key;
            if (occ >= QUEUE_DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               // Skip every entry whose key is not greater, so ties keep arrival order.
               while (slot < occ && !($signed(slot_key[slot]) > $signed(rq.entry_key)))
                  slot++;
               for (int i = occ; i > slot; i--) begin
                  slot_key[i] = slot_key[i - 1];
                  slot_id[i]  = slot_id[i - 1];
               end
               slot_key[slot] = rq.entry_key;
               slot_id[slot]  = rq.entry_id;
               occ++;
               rs.status = STAT_OK;
            end
         end
         MODE_POP: begin
            if (occ == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.status  = STAT_OK;
               rs.out_id  = slot_id[0];
               rs.out_key = slot_key[0];
               close_slot(0);
            end
         end
         default: begin
            while (slot < occ && slot_id[slot] != rq.entry_id)
               slot++;
            if (slot >= occ) begin
               rs.status = STAT_NOTFOUND;
               rs.out_id = rq.entry_id;
            end else begin
               rs.status  = STAT_OK;
               rs.found   = 1'b1;
               rs.out_id  = slot_id[slot];
               rs.out_key = slot_key[slot];
               if (rq.mode == MODE_REMOVE)
                  close_slot(slot);
            end
         end
      endcase
      rs.occupancy = occ[OCC_BITS-1:0];
      return rs;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                  act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         occ = 0;
         outcome_fifo.delete();
         pending_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            outcome_fifo.push_back(queue_op(req_chan.payload));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (outcome_fifo.size() == 0) begin
               $display("%0t ns: response with none outstanding, expected nothing, actual %h",
                        $time, got);
               fail_count++;
            end else begin
               want = outcome_fifo.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("out_id", 32'(want.out_id), 32'(got.out_id));
               check_field("out_key", want.out_key, got.out_key);
               check_field("found", 32'(want.found), 32'(got.found));
               check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
               checked_count++;
               if (want.status == STAT_FULL)
                  full_hits++;
               if (want.status == STAT_EMPTY)
                  empty_hits++;
               if (want.status == STAT_NOTFOUND)
                  absent_hits++;
            end
         end
         pending_count = outcome_fifo.size();
      end
   end

endmodule

// ===== dv/stable_sorted_key_queue_top_tb.sv =====
// Testbench top for the stable sorted key queue: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on sskq_pkg, both channel
// interfaces, stable_sorted_key_queue_top and sskq_checker.
`timescale 1ns / 1ps

module stable_sorted_key_queue_top_tb;
   import sskq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 527;
   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 40;

   localparam logic signed [KEY_BITS-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;

   // Traffic mixes of the random part.
   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;

   logic clock;
   logic reset;

   sskq_req_if req_chan ();
   sskq_rsp_if rsp_chan ();

   int fail_count;
   int pending_count;
   int checked_count;
   int full_hits;
   int empty_hits;
   int absent_hits;

   int mode_sent [4];
   int idle_cycles;
   int rx_cycle;
   int rx_style;
   int rx_hold;

   stable_sorted_key_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_PORT_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   sskq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .full_hits    (full_hits),
      .empty_hits   (empty_hits),
      .absent_hits  (absent_hits)
   );

   always #1 clock = ~clock;

   // Present one request at the falling edge and hold it until the block takes it.
   // Valid stays high on return so a burst can follow without a gap.
   task automatic push_req(input logic [1:0] mode, input logic [ID_PORT_BITS-1:0] id,
                           input logic signed [KEY_BITS-1:0] key);
      req_chan.payload.mode      = mode;
      req_chan.payload.entry_id  = id;
      req_chan.payload.entry_key = key;
      req_chan.valid             = 1'b1;
      do
         @(posedge clock);
      while (!req_chan.ready);
      mode_sent[mode]++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Ids mostly come from a small pool so that look-ups and removals hit, and
   // duplicates occur.
   function automatic logic [ID_PORT_BITS-1:0] pick_id();
      if ($urandom_range(0, 9) < 7)
         return ID_PORT_BITS'($urandom_range(0, 7));
      return ID_PORT_BITS'($urandom_range(0, 255));
   endfunction

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 6)
         return KEY_BITS'($signed($urandom_range(0, 4)) - 2);
      if (sel == 6)
         return KEY_MAX;
      if (sel == 7)
         return KEY_MIN;
      if (sel == 8)
         return KEY_MIN + 1;
      return $urandom();
   endfunction

   function automatic logic [1:0] pick_mode(input int phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL:  return (roll < 60) ? MODE_INSERT : (roll < 70) ? MODE_POP :
                             (roll < 85) ? MODE_REMOVE : MODE_LOOKUP;
         PHASE_DRAIN: return (roll < 15) ? MODE_INSERT : (roll < 60) ? MODE_POP :
                             (roll < 85) ? MODE_REMOVE : MODE_LOOKUP;
         default:     return 2'($urandom_range(0, 3));
      endcase
   endfunction

   // Receiver back-pressure: the style is re-drawn at random, one of four.
   always @(negedge clock) begin
      if (!reset) begin
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_style = $urandom_range(0, 3);
         case (rx_style)
            0: rsp_chan.ready = 1'b1;
            1: rsp_chan.ready = ($urandom_range(0, 9) < 6);
            2: rsp_chan.ready = (rx_cycle % 4 == 0);
            default: begin
               if (rx_hold == 0) begin
                  rsp_chan.ready = !rsp_chan.ready;
                  rx_hold = rsp_chan.ready ? $urandom_range(1, 4) : $urandom_range(1, 15);
               end else begin
                  rx_hold--;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
            $display("FAIL stable_sorted_key_queue_top");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      int burst;
      int gap;
      int phase;
      bit drained_mid;
      clock          = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      rx_cycle       = 0;
      rx_style       = 0;
      rx_hold        = 0;
      idle_cycles    = 0;
      sent           = 0;
      phase          = PHASE_FILL;
      drained_mid    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty queue, extreme keys, ties, duplicate ids, full queue.
      push_req(MODE_POP, 8'h00, 32'sh0);
      push_req(MODE_LOOKUP, 8'h05, KEY_MAX);
      push_req(MODE_REMOVE, 8'h05, KEY_MIN);
      push_req(MODE_INSERT, 8'hFF, KEY_MAX);
      push_req(MODE_INSERT, 8'h00, KEY_MIN);
      push_req(MODE_INSERT, 8'h03, 32'sh0);
      push_req(MODE_INSERT, 8'hAA, -32'sd1);
      push_req(MODE_INSERT, 8'h55, 32'sd1);
      push_req(MODE_INSERT, 8'h03, 32'sh0);
      push_req(MODE_INSERT, 8'h04, 32'sh0);
      push_req(MODE_INSERT, 8'h01, KEY_MIN);
      push_req(MODE_INSERT, 8'h02, KEY_MAX);
      push_req(MODE_INSERT, 8'h10, 32'sd100);
      push_req(MODE_INSERT, 8'h11, -32'sd100);
      push_req(MODE_INSERT, 8'h12, 32'sd100);
      push_req(MODE_INSERT, 8'h13, 32'sd7);
      push_req(MODE_INSERT, 8'h03, 32'sd7);
      push_req(MODE_INSERT, 8'h14, -32'sd1);
      push_req(MODE_INSERT, 8'h15, 32'sh1234_5678);
      push_req(MODE_INSERT, 8'h77, 32'sh0);
      push_req(MODE_LOOKUP, 8'h03, 32'sh5A5A_5A5A);
      push_req(MODE_REMOVE, 8'h03, 32'sh0);
      push_req(MODE_REMOVE, 8'hC8, 32'sh0);
      push_req(MODE_POP, 8'hFF, -32'sd1);
      push_req(MODE_LOOKUP, 8'h02, 32'sh0);

      // Hold off until the block has answered everything so far.
      wait_drained();

      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            if (sent % 40 == 0)
               phase = $urandom_range(PHASE_FILL, PHASE_MIXED);
            push_req(pick_mode(phase), pick_id(), pick_key());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            drained_mid = 1'b1;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d inserts, %0d pops, %0d removes and %0d look-ups; %0d responses checked.",
               mode_sent[MODE_INSERT], mode_sent[MODE_POP], mode_sent[MODE_REMOVE],
               mode_sent[MODE_LOOKUP], checked_count);
      $display("Full rejections: %0d, pops on empty: %0d, ids not found: %0d.",
               full_hits, empty_hits, absent_hits);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS stable_sorted_key_queue_top");
      end else begin
         $display("FAIL stable_sorted_key_queue_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sskq_pkg.sv
hdl/sskq_req_if.sv
hdl/sskq_rsp_if.sv
hdl/sskq_ram.sv
hdl/stable_sorted_key_queue_top.sv
dv/sskq_checker.sv
dv/stable_sorted_key_queue_top_tb.sv
